// ===== src/cle_pkg.sv =====
package cle_pkg;

  localparam int LINE_CAPACITY_DEF = 64;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_BS1,
    S_SP,
    S_BS2,
    S_EOL,
    S_LINE,
    S_EMPTY
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       overflow;
    logic       last;
  } result_t;

endpackage

// ===== src/cle_out_reg.sv =====
module cle_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cle_pkg::result_t    push_data,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_data_byte,
  output logic                out_overflow,
  output logic                out_last
);

  logic             valid_r;
  logic             valid_nxt;
  cle_pkg::result_t data_r;

  // a new beat may enter when the register is empty or is being drained
  assign load_ok = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load_ok) begin
      valid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && load_ok) begin
      data_r <= push_data;
    end
  end

  assign out_valid     = valid_r;
  assign out_kind      = data_r.kind;
  assign out_data_byte = data_r.data_byte;
  assign out_overflow  = data_r.overflow;
  assign out_last      = data_r.last;

endmodule

// ===== src/console_line_editor_top.sv =====
// Console line editor. Takes one received byte per accepted beat on in_rx_byte and
// returns its results on the out_ channel, one beat each, the final one marked by
// out_last. A byte is taken only while the sequencer is idle (in_stall low); its
// results then leave through an output register at up to one per cycle while out_stall
// is low: an ordinary byte gives its echo, a backspace or DEL gives BS, SP, BS, and a
// line end gives its echo and then an empty-line beat or the bytes of the line.
// The line bytes are read back one per cycle while out_stall is low from a line memory of
// LINE_CAPACITY bytes with separate read and write addresses and a registered read.
// An LF right after a line-ending CR is swallowed with no result.
module console_line_editor_top #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_overflow,
  output logic       out_last
);

  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(LINE_CAPACITY);

  cle_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic             after_cr_r, after_cr_nxt;
  logic [CW-1:0]    len_r, len_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             ovf_r, ovf_nxt;

  logic [7:0]       mem [LINE_CAPACITY];
  logic [7:0]       rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  logic             accept;
  logic             is_bs;
  logic             is_eol;
  logic             drop;
  logic             full;
  logic [CW-1:0]    fill_eff;
  logic             load_ok;
  logic             push;
  cle_pkg::result_t res;

  assign in_stall = (state_r != cle_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_bs    = (in_rx_byte == cle_pkg::CH_BS) || (in_rx_byte == cle_pkg::CH_DEL);
  assign is_eol   = (in_rx_byte == cle_pkg::CH_CR) || (in_rx_byte == cle_pkg::CH_LF);
  assign drop     = after_cr_r && (in_rx_byte == cle_pkg::CH_LF);
  assign full     = (fill_r >= CAP);
  assign fill_eff = full ? '0 : fill_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cle_pkg::S_IDLE: begin
        if (accept && !drop) begin
          if (is_bs) begin
            state_nxt = cle_pkg::S_BS1;
          end else if (is_eol) begin
            state_nxt = cle_pkg::S_EOL;
          end else begin
            state_nxt = cle_pkg::S_ECHO;
          end
        end
      end
      cle_pkg::S_ECHO: if (load_ok) state_nxt = cle_pkg::S_IDLE;
      cle_pkg::S_BS1:  if (load_ok) state_nxt = cle_pkg::S_SP;
      cle_pkg::S_SP:   if (load_ok) state_nxt = cle_pkg::S_BS2;
      cle_pkg::S_BS2:  if (load_ok) state_nxt = cle_pkg::S_IDLE;
      cle_pkg::S_EOL: begin
        if (load_ok) begin
          state_nxt = (len_r == '0) ? cle_pkg::S_EMPTY : cle_pkg::S_LINE;
        end
      end
      cle_pkg::S_LINE: begin
        if (load_ok && (idx_r + CW'(1) == len_r)) begin
          state_nxt = cle_pkg::S_IDLE;
        end
      end
      cle_pkg::S_EMPTY: if (load_ok) state_nxt = cle_pkg::S_IDLE;
      default: state_nxt = cle_pkg::S_IDLE;
    endcase
  end

  // datapath and result beats
  always_comb begin
    fill_nxt     = fill_r;
    after_cr_nxt = after_cr_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    byte_nxt     = byte_r;
    ovf_nxt      = ovf_r;
    wr_en        = 1'b0;
    wr_addr      = fill_eff[AW-1:0];
    rd_en        = 1'b0;
    rd_addr      = '0;
    push         = 1'b0;
    res          = '{kind: cle_pkg::KIND_ECHO, data_byte: byte_r, overflow: ovf_r, last: 1'b0};
    unique case (state_r)
      cle_pkg::S_IDLE: begin
        if (accept) begin
          after_cr_nxt = 1'b0;
          if (!drop) begin
            byte_nxt = in_rx_byte;
            ovf_nxt  = full;
            if (is_bs) begin
              fill_nxt = (fill_eff == '0) ? '0 : fill_eff - CW'(1);
            end else if (is_eol) begin
              len_nxt      = fill_eff;
              fill_nxt     = '0;
              after_cr_nxt = (in_rx_byte == cle_pkg::CH_CR);
            end else begin
              wr_en    = 1'b1;
              fill_nxt = fill_eff + CW'(1);
            end
          end
        end
      end
      cle_pkg::S_ECHO: begin
        push     = 1'b1;
        res.last = 1'b1;
      end
      cle_pkg::S_BS1: begin
        push          = 1'b1;
        res.data_byte = cle_pkg::CH_BS;
      end
      cle_pkg::S_SP: begin
        push          = 1'b1;
        res.data_byte = cle_pkg::CH_SP;
      end
      cle_pkg::S_BS2: begin
        push          = 1'b1;
        res.data_byte = cle_pkg::CH_BS;
        res.last      = 1'b1;
      end
      cle_pkg::S_EOL: begin
        push = 1'b1;
        if (load_ok) begin
          // prefetch the first line byte
          idx_nxt = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      cle_pkg::S_LINE: begin
        push          = 1'b1;
        res.kind      = cle_pkg::KIND_LINE;
        res.data_byte = rd_data_r;
        res.last      = (idx_r + CW'(1) == len_r);
        if (load_ok) begin
          idx_nxt = idx_r + CW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_nxt[AW-1:0];
        end
      end
      cle_pkg::S_EMPTY: begin
        push          = 1'b1;
        res.kind      = cle_pkg::KIND_EMPTY;
        res.data_byte = cle_pkg::CH_NUL;
        res.last      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cle_pkg::S_IDLE;
      fill_r     <= '0;
      after_cr_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      after_cr_r <= after_cr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    byte_r <= byte_nxt;
    ovf_r  <= ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  cle_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .push_data     (res),
    .load_ok       (load_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_overflow  (out_overflow),
    .out_last      (out_last)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP)
    else $error("fill count above capacity");

  a_line_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cle_pkg::S_LINE) |-> (idx_r < len_r))
    else $error("line read index past line length");

  a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !drop && !is_bs && !is_eol && !full) |=> (fill_r == $past(fill_r) + CW'(1)))
    else $error("stored byte did not advance fill count");

  a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !drop && is_eol) |=> (fill_r == '0 && state_r == cle_pkg::S_EOL))
    else $error("line end did not clear the store");

endmodule

// ===== bench/console_line_editor_top_tb.sv =====
`timescale 1ns / 100ps

module console_line_editor_top_tb;

  localparam int LINE_CAP = cle_pkg::LINE_CAPACITY_DEF;

  localparam logic [7:0] OPENING [20] = '{
    8'h00, 8'hFF, 8'h7E, cle_pkg::CH_CR, cle_pkg::CH_LF, cle_pkg::CH_LF,
    cle_pkg::CH_CR, cle_pkg::CH_CR, 8'h41, cle_pkg::CH_BS, cle_pkg::CH_DEL,
    cle_pkg::CH_BS, 8'h20, 8'h01, cle_pkg::CH_DEL, cle_pkg::CH_LF,
    cle_pkg::CH_CR, 8'h55, cle_pkg::CH_LF, 8'h80
  };

  class echo_line_scoreboard;
    logic [7:0]       line_chars [LINE_CAP];
    int unsigned      char_count = 0;
    bit               cr_ended = 1'b0;
    cle_pkg::result_t pending_results [$];
    int unsigned      errors = 0;

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function void push_result(cle_pkg::kind_t kind, logic [7:0] data, logic ovf);
      cle_pkg::result_t r;
      r.kind = kind;
      r.data_byte = data;
      r.overflow = ovf;
      r.last = 1'b0;
      pending_results.push_back(r);
    endfunction

    // Work out the beats that one accepted input byte must produce.
    function void note_rx_byte(logic [7:0] b);
      logic             ovf;
      cle_pkg::result_t tail;
      if (cr_ended && b == cle_pkg::CH_LF) begin
        cr_ended = 1'b0;
        return;
      end
      cr_ended = 1'b0;
      ovf = 1'b0;
      if (char_count >= LINE_CAP) begin
        char_count = 0;
        ovf = 1'b1;
      end
      if (b == cle_pkg::CH_BS || b == cle_pkg::CH_DEL) begin
        if (char_count > 0) char_count--;
        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, ovf);
        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_SP, ovf);
        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, ovf);
      end else if (b == cle_pkg::CH_CR || b == cle_pkg::CH_LF) begin
        push_result(cle_pkg::KIND_ECHO, b, ovf);
        if (char_count == 0) begin
          push_result(cle_pkg::KIND_EMPTY, cle_pkg::CH_NUL, ovf);
        end else begin
          for (int i = 0; i < char_count; i++)
            push_result(cle_pkg::KIND_LINE, line_chars[i], ovf);
        end
        char_count = 0;
        cr_ended = (b == cle_pkg::CH_CR);
      end else begin
        line_chars[char_count] = b;
        char_count++;
        push_result(cle_pkg::KIND_ECHO, b, ovf);
      end
      // flag the final beat of this byte
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    endfunction

    task check_result(logic [1:0] kind, logic [7:0] data, logic ovf, logic last);
      cle_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d data=%02h", kind, data));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, want %0d", kind, want.kind));
      if (data !== want.data_byte)
        report($sformatf("data_byte %02h, want %02h", data, want.data_byte));
      if (ovf !== want.overflow)
        report($sformatf("overflow %b, want %b", ovf, want.overflow));
      if (last !== want.last)
        report($sformatf("last %b, want %b", last, want.last));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_overflow;
  logic       out_last;

  echo_line_scoreboard sb;
  bit          in_burst;
  bit          out_burst;
  int unsigned in_count;

  console_line_editor_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_data_byte(out_data_byte),
    .out_overflow (out_overflow),
    .out_last     (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Random line content: anything that neither edits nor ends the line.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cle_pkg::CH_BS || b == cle_pkg::CH_DEL ||
           b == cle_pkg::CH_CR || b == cle_pkg::CH_LF);
    return b;
  endfunction

  task send_byte(logic [7:0] b);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rx_byte(b);
    in_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_kind, out_data_byte, out_overflow, out_last);
  end

  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    out_burst = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned stop_at;
    sb = new;
    in_count = 0;
    in_burst = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_byte(OPENING[i]);

    stop_at = in_count + 160;
    // fill the store, overflow on a DEL, then end a line of LINE_CAP - 1 bytes
    repeat (LINE_CAP) send_byte(text_byte());
    send_byte(cle_pkg::CH_DEL);
    repeat (LINE_CAP - 1) send_byte(text_byte());
    send_byte(cle_pkg::CH_CR);

    while (in_count < stop_at) begin
      in_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        n = LINE_CAP - $urandom_range(0, 1);
        repeat (n) send_byte(text_byte());
      end else begin
        n = $urandom_range(0, 12);
        repeat (n) begin
          pick = $urandom_range(0, 19);
          if (pick < 2) send_byte(cle_pkg::CH_BS);
          else if (pick < 4) send_byte(cle_pkg::CH_DEL);
          else if (pick == 4) send_byte(8'($urandom_range(0, 255)));
          else send_byte(text_byte());
        end
      end
      pick = $urandom_range(0, 5);
      case (pick)
        0: send_byte(cle_pkg::CH_CR);
        1: send_byte(cle_pkg::CH_LF);
        2: begin
          send_byte(cle_pkg::CH_CR);
          send_byte(cle_pkg::CH_LF);
        end
        3: begin
          send_byte(cle_pkg::CH_CR);
          send_byte(cle_pkg::CH_CR);
          send_byte(cle_pkg::CH_LF);
        end
        4: send_byte(text_byte());
        default: send_byte(cle_pkg::CH_BS);
      endcase
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    // allow a swallowed LF or stray beats to surface
    repeat (LINE_CAP + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cle_pkg.sv
src/cle_out_reg.sv
src/console_line_editor_top.sv
bench/console_line_editor_top_tb.sv
